// ===== design/ord_pkg.sv =====
// Shared types, request and error codes and ring index arithmetic.
// No dependencies.
package ord_pkg;

  localparam int CNT_W   = 9;
  localparam int SUM_W   = CNT_W + 1;
  localparam int DATA_W  = 8;
  localparam int REQ_W   = 3;
  localparam int ERR_W   = 2;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_TAIL  = 3'd0,
    REQ_PUSH_HEAD  = 3'd1,
    REQ_POP_TAIL   = 3'd2,
    REQ_POP_HEAD   = 3'd3,
    REQ_READ_AT    = 3'd4,
    REQ_WRITE_AT   = 3'd5,
    REQ_CLEAR      = 3'd6,
    REQ_NONE       = 3'd7
  } req_t;

  localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
  localparam logic [ERR_W-1:0] ERR_EMPTY     = 2'd1;
  localparam logic [ERR_W-1:0] ERR_RANGE     = 2'd2;
  localparam logic [ERR_W-1:0] ERR_ZERO_CAP  = 2'd3;

  localparam logic [PADDR_W-1:0] ADDR_CAPACITY = 3'd0;

  typedef struct packed {
    logic load;
    logic exec;
    logic clear;
  } ord_cmd_t;

  // (a + b) mod cap, with a, b below cap or b equal to cap
  function automatic logic [SUM_W-1:0] ring_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b,
                                                 input logic [CNT_W-1:0] cap);
    logic [SUM_W-1:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, cap}) begin
      s = s - {1'b0, cap};
    end
    return s;
  endfunction

endpackage

// ===== design/ord_ctrl.sv =====
// Request sequencer: accept, execute, respond.
// Depends on ord_pkg.
module ord_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              cfg_wr,
  output logic              busy,
  output logic              resp_strobe,
  output ord_pkg::ord_cmd_t cmd
);
  import ord_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_RESP = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: state_nxt = ST_RESP;
      ST_RESP: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy        = (state_r != ST_IDLE);
  assign resp_strobe = (state_r == ST_RESP);
  assign cmd.load    = (state_r == ST_IDLE) && start;
  assign cmd.exec    = (state_r == ST_EXEC);
  assign cmd.clear   = cfg_wr;

endmodule

// ===== design/ord_dp.sv =====
// Ring datapath: byte store, head and count registers, slot and error logic.
// Depends on ord_pkg.
module ord_dp #(
  parameter int DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ord_pkg::ord_cmd_t             cmd,
  input  logic [ord_pkg::CNT_W-1:0]     cap,
  input  logic [ord_pkg::REQ_W-1:0]     req_type,
  input  logic [ord_pkg::DATA_W-1:0]    item_value,
  input  logic [ord_pkg::CNT_W-1:0]     position,
  output logic [ord_pkg::DATA_W-1:0]    read_value,
  output logic [ord_pkg::ERR_W-1:0]     error_code,
  output logic [ord_pkg::CNT_W-1:0]     fill_count,
  output logic                          is_full,
  output logic                          is_empty
);
  import ord_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_W-1:0] mem [DEPTH];

  req_t              req_r;
  logic [DATA_W-1:0] item_r;
  logic [CNT_W-1:0]  pos_r;
  logic [CNT_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ERR_W-1:0]  err_r, err_nxt;
  logic [DATA_W-1:0] rdata_r;
  logic              rd_ok_r;

  logic [SUM_W-1:0]  slot;
  logic [SUM_W-1:0]  head_inc_sum;
  logic              we, re;
  logic [CNT_W-1:0]  head_inc, head_dec, pos_m1;

  always_comb begin
    head_inc_sum = ring_add(head_r, CNT_W'(1), cap);
    head_inc = head_inc_sum[CNT_W-1:0];
    head_dec = (head_r == '0) ? cap - CNT_W'(1) : head_r - CNT_W'(1);
    pos_m1   = pos_r - CNT_W'(1);
    head_nxt  = head_r;
    count_nxt = count_r;
    err_nxt   = ERR_OK;
    slot      = '0;
    we        = 1'b0;
    re        = 1'b0;
    case (req_r)
      REQ_PUSH_TAIL: begin
        if (cap == '0) begin
          err_nxt = ERR_ZERO_CAP;
        end else begin
          slot = ring_add(head_r, count_r, cap);
          we   = 1'b1;
          if (count_r >= cap) head_nxt = head_inc;
          else count_nxt = count_r + CNT_W'(1);
        end
      end
      REQ_PUSH_HEAD: begin
        if (cap == '0) begin
          err_nxt = ERR_ZERO_CAP;
        end else begin
          head_nxt = head_dec;
          slot     = {1'b0, head_dec};
          we       = 1'b1;
          if (count_r < cap) count_nxt = count_r + CNT_W'(1);
        end
      end
      REQ_POP_TAIL, REQ_POP_HEAD: begin
        if (count_r == '0) begin
          err_nxt = ERR_EMPTY;
        end else begin
          if (req_r == REQ_POP_HEAD) head_nxt = head_inc;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      REQ_READ_AT, REQ_WRITE_AT: begin
        if (pos_r == '0 || pos_r > count_r) begin
          err_nxt = ERR_RANGE;
        end else begin
          slot = ring_add(head_r, pos_m1, cap);
          we   = (req_r == REQ_WRITE_AT);
          re   = (req_r == REQ_READ_AT);
        end
      end
      REQ_CLEAR: begin
        head_nxt  = '0;
        count_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= req_t'(req_type);
      item_r <= item_value;
      pos_r  <= position;
    end
    if (cmd.exec) begin
      err_r <= err_nxt;
      if (we) mem[AW'(slot)] <= item_r;
      if (re) rdata_r <= mem[AW'(slot)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      rd_ok_r <= 1'b0;
    end else if (cmd.clear) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      rd_ok_r <= re;
    end
  end

  assign read_value = rd_ok_r ? rdata_r : '0;
  assign error_code = err_r;
  assign fill_count = count_r;
  assign is_full    = (count_r == cap);
  assign is_empty   = (count_r == '0) && (cap != '0);

endmodule

// ===== design/overwriting_ring_deque_unit.sv =====
// Overwriting byte ring deque: APB capacity register, sequencer and datapath.
// Result strobe in the respond state, after the execute state of a taken
// request (start && !busy). A new request is taken only in idle, after the
// accept/execute/respond sequence (single store port, registered read data).
// Reset: synchronous, clears head, count and sequencer; capacity resets to 256.
// Store contents are not reset. The receiver cannot stall results.
module overwriting_ring_deque_unit #(
  parameter int DEPTH = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [ord_pkg::REQ_W-1:0]       in_req_type,
  input  logic [ord_pkg::DATA_W-1:0]      in_item_value,
  input  logic [ord_pkg::CNT_W-1:0]       in_position,
  output logic                            out_strobe,
  output logic [ord_pkg::DATA_W-1:0]      out_read_value,
  output logic [ord_pkg::ERR_W-1:0]       out_error_code,
  output logic [ord_pkg::CNT_W-1:0]       out_fill_count,
  output logic                            out_is_full,
  output logic                            out_is_empty,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ord_pkg::PADDR_W-1:0]     paddr,
  input  logic [ord_pkg::PDATA_W-1:0]     pwdata,
  output logic [ord_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready
);
  import ord_pkg::*;

  localparam logic [CNT_W-1:0] CAP_LIMIT =
    (DEPTH > (1 << CNT_W) - 1) ? CNT_W'((1 << CNT_W) - 1) : CNT_W'(DEPTH);

  logic [CNT_W-1:0] cap_r;
  logic [CNT_W-1:0] cap_eff;
  logic             cfg_wr;
  ord_cmd_t         cmd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_CAPACITY);
  assign prdata = (paddr == ADDR_CAPACITY) ? {{(PDATA_W-CNT_W){1'b0}}, cap_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CNT_W'(256);
    end else if (cfg_wr) begin
      cap_r <= pwdata[CNT_W-1:0];
    end
  end

  assign cap_eff = (cap_r > CAP_LIMIT) ? CAP_LIMIT : cap_r;

  ord_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .cfg_wr      (cfg_wr),
    .busy        (busy),
    .resp_strobe (out_strobe),
    .cmd         (cmd)
  );

  ord_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cap        (cap_eff),
    .req_type   (in_req_type),
    .item_value (in_item_value),
    .position   (in_position),
    .read_value (out_read_value),
    .error_code (out_error_code),
    .fill_count (out_fill_count),
    .is_full    (out_is_full),
    .is_empty   (out_is_empty)
  );

  a_accept_to_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> ##1 out_strobe)
    else $error("result strobe not two cycles after request");

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy && !$past(out_strobe))
    else $error("strobe outside a request or repeated");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_fill_count <= cap_eff)
    else $error("fill count above capacity");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_is_full && out_is_empty))
    else $error("full and empty together");

endmodule
